[src/ptc_pkg.sv]
// Shared types, constants and the control program of the PID thrust controller.
// Used by ptc_sequencer, ptc_datapath and pid_thrust_controller; no dependencies.
package ptc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 39;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 3'd0,
        CFG_KP     = 3'd1,
        CFG_KI     = 3'd2,
        CFG_KD     = 3'd3,
        CFG_ILIM   = 3'd4,
        CFG_TLIM   = 3'd5,
        CFG_ALPHA  = 3'd6,
        CFG_DMEAS  = 3'd7
    } t_cfg_idx;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        UOP_NOP     = 4'd0,
        UOP_ACCEPT  = 4'd1,
        UOP_ERR     = 4'd2,
        UOP_INTEG   = 4'd3,
        UOP_MLO     = 4'd4,
        UOP_MHI     = 4'd5,
        UOP_ACC     = 4'd6,
        UOP_WB      = 4'd7,
        UOP_CMD     = 4'd8,
        UOP_LAG     = 4'd9,
        UOP_INSTANT = 4'd10,
        UOP_OUT     = 4'd11
    } t_uop;

    // multiplier operand source, loaded alongside the operation
    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_ERR  = 3'd1,
        SRC_SUM  = 3'd2,
        SRC_DOP  = 3'd3,
        SRC_DIFF = 3'd4
    } t_src;

    typedef enum logic [1:0] {
        GAIN_KP    = 2'd0,
        GAIN_KI    = 2'd1,
        GAIN_KD    = 2'd2,
        GAIN_ALPHA = 2'd3
    } t_gsel;

    typedef enum logic [1:0] {
        DST_NONE = 2'd0,
        DST_P    = 2'd1,
        DST_I    = 2'd2,
        DST_D    = 2'd3
    } t_dst;

    typedef enum logic [2:0] {
        COND_NEVER     = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_NO_INPUT  = 3'd2,
        COND_OUT_BUSY  = 3'd3,
        COND_ALPHA_ONE = 3'd4
    } t_cond;

    localparam int STEP_W = 5;
    localparam int NUM_STEPS = 23;
    localparam logic [STEP_W-1:0] STEP_IDLE    = 5'd0;
    localparam logic [STEP_W-1:0] STEP_LAG     = 5'd20;
    localparam logic [STEP_W-1:0] STEP_INSTANT = 5'd21;
    localparam logic [STEP_W-1:0] STEP_OUT     = 5'd22;

    typedef struct packed {
        t_uop              op;
        t_src              src;
        t_gsel             gsel;
        t_dst              dst;
        t_cond             cond;
        logic [STEP_W-1:0] target;
        logic              wrap;
    } t_ucode;

    // status seen by the sequencer's jump conditions
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic alpha_one;
    } t_seq_status;

    typedef struct packed {
        logic [31:0] sample_index;
        logic [31:0] control_error;
        logic [31:0] prop_term;
        logic [31:0] integ_term;
        logic [31:0] deriv_term;
        logic [30:0] applied_thrust;
    } t_result;

    function automatic t_ucode uw(input t_uop op, input t_src src, input t_gsel gsel,
                                  input t_dst dst, input t_cond cond,
                                  input logic [STEP_W-1:0] target, input logic wrap);
        t_ucode w;
        w.op = op;
        w.src = src;
        w.gsel = gsel;
        w.dst = dst;
        w.cond = cond;
        w.target = target;
        w.wrap = wrap;
        return w;
    endfunction

    // control program: one word per step
    function automatic t_ucode ptc_ucode(input logic [STEP_W-1:0] step);
        t_ucode w;
        case (step)
            5'd0:  w = uw(UOP_ACCEPT, SRC_NONE, GAIN_KP, DST_NONE, COND_NO_INPUT,
                          STEP_IDLE, 1'b0);
            5'd1:  w = uw(UOP_ERR, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd2:  w = uw(UOP_INTEG, SRC_ERR, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd3:  w = uw(UOP_MLO, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd4:  w = uw(UOP_MHI, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd5:  w = uw(UOP_ACC, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd6:  w = uw(UOP_WB, SRC_SUM, GAIN_KI, DST_P, COND_NEVER, STEP_IDLE, 1'b0);
            5'd7:  w = uw(UOP_MLO, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd8:  w = uw(UOP_MHI, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd9:  w = uw(UOP_ACC, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd10: w = uw(UOP_WB, SRC_DOP, GAIN_KD, DST_I, COND_NEVER, STEP_IDLE, 1'b0);
            5'd11: w = uw(UOP_MLO, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd12: w = uw(UOP_MHI, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd13: w = uw(UOP_ACC, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd14: w = uw(UOP_WB, SRC_NONE, GAIN_KP, DST_D, COND_NEVER, STEP_IDLE, 1'b0);
            5'd15: w = uw(UOP_CMD, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd16: w = uw(UOP_NOP, SRC_DIFF, GAIN_ALPHA, DST_NONE, COND_ALPHA_ONE,
                          STEP_INSTANT, 1'b0);
            5'd17: w = uw(UOP_MLO, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd18: w = uw(UOP_MHI, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd19: w = uw(UOP_ACC, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER, STEP_IDLE, 1'b0);
            5'd20: w = uw(UOP_LAG, SRC_NONE, GAIN_KP, DST_NONE, COND_ALWAYS, STEP_OUT, 1'b0);
            5'd21: w = uw(UOP_INSTANT, SRC_NONE, GAIN_KP, DST_NONE, COND_NEVER,
                          STEP_IDLE, 1'b0);
            5'd22: w = uw(UOP_OUT, SRC_NONE, GAIN_KP, DST_NONE, COND_OUT_BUSY,
                          STEP_OUT, 1'b1);
            default: w = uw(UOP_NOP, SRC_NONE, GAIN_KP, DST_NONE, COND_ALWAYS,
                            STEP_IDLE, 1'b0);
        endcase
        return w;
    endfunction

endpackage

[src/ptc_sequencer.sv]
// Step counter and control-program fetch with conditional jumps.
// Depends on ptc_pkg for the control word, status struct and program table.
module ptc_sequencer
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_seq_status i_status,
    output t_ucode      o_cw
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ucode            cw;
    logic              take;

    assign cw = ptc_ucode(r_step);
    assign o_cw = cw;

    // evaluate the jump condition of the current word
    always_comb begin
        unique case (cw.cond)
            COND_NEVER:     take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_INPUT:  take = !i_status.in_valid;
            COND_OUT_BUSY:  take = i_status.out_busy;
            COND_ALPHA_ONE: take = i_status.alpha_one;
            default:        take = 1'b0;
        endcase
    end

    // jump, wrap to the idle step, or advance
    always_comb begin
        if (take) begin
            n_step = cw.target;
        end else if (cw.wrap || r_step == STEP_W'(NUM_STEPS - 1)) begin
            n_step = STEP_IDLE;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[src/ptc_datapath.sv]
// Configuration registers, controller state and the shared multiply datapath.
// Depends on ptc_pkg; driven one operation per cycle by ptc_sequencer.
module ptc_datapath
    import ptc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [31:0]           i_measured_altitude,
    input  t_ucode                i_cw,
    input  logic                  i_out_busy,
    output logic                  o_alpha_one,
    output logic                  o_res_load,
    output t_result               o_result
);

    localparam logic signed [31:0] S32_TOP = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_BOT = 32'sh8000_0000;

    // configuration
    logic signed [31:0] r_target;
    logic [23:0]        r_kp;
    logic [23:0]        r_ki;
    logic [23:0]        r_kd;
    logic [38:0]        r_ilim;
    logic [30:0]        r_tlim;
    logic [16:0]        r_alpha;
    logic               r_dmeas;

    // controller state
    logic signed [39:0] r_error_sum;
    logic signed [31:0] r_last_error;
    logic signed [31:0] r_last_meas;
    logic [30:0]        r_thrust;
    logic [31:0]        r_tick;
    logic               r_ticked;

    // working registers
    logic signed [31:0] r_meas;
    logic signed [31:0] r_err;
    logic signed [32:0] r_dop;
    logic signed [31:0] r_pt;
    logic signed [31:0] r_it;
    logic signed [31:0] r_dt;
    logic [30:0]        r_cmd;
    logic [39:0]        r_mag;
    logic               r_neg;
    logic [23:0]        r_gain;
    logic [55:0]        r_prod;
    logic [63:0]        r_acc;

    logic signed [32:0] err_diff;
    logic signed [31:0] err_sat;
    logic signed [40:0] sum_raw;
    logic signed [40:0] lim_pos;
    logic signed [40:0] lim_neg;
    logic signed [39:0] sum_clamp;
    logic signed [32:0] dop_new;
    logic signed [40:0] opnd;
    logic [40:0]        opnd_abs;
    logic [23:0]        gain_sel;
    logic signed [31:0] diff_cmd;
    logic [31:0]        mul_a;
    logic [55:0]        mul_p;
    logic [47:0]        rq;
    logic signed [31:0] term_sat;
    logic [31:0]        delta;
    logic [31:0]        thrust_sum;
    logic signed [33:0] cmd_raw;
    logic [30:0]        cmd_clamp;
    logic               res_load;

    // saturated error
    assign err_diff = {r_target[31], r_target} - {r_meas[31], r_meas};
    always_comb begin
        if (err_diff > 33'sd2147483647) begin
            err_sat = S32_TOP;
        end else if (err_diff < -33'sd2147483648) begin
            err_sat = S32_BOT;
        end else begin
            err_sat = err_diff[31:0];
        end
    end

    // clamped error sum and derivative operand
    assign sum_raw = {r_error_sum[39], r_error_sum} + {{9{r_err[31]}}, r_err};
    assign lim_pos = {2'b00, r_ilim};
    assign lim_neg = -lim_pos;
    always_comb begin
        if (sum_raw > lim_pos) begin
            sum_clamp = lim_pos[39:0];
        end else if (sum_raw < lim_neg) begin
            sum_clamp = lim_neg[39:0];
        end else begin
            sum_clamp = sum_raw[39:0];
        end
    end
    assign dop_new = r_dmeas ? ({r_last_meas[31], r_last_meas} - {r_meas[31], r_meas})
                             : ({r_err[31], r_err} - {r_last_error[31], r_last_error});

    // operand select and magnitude for the multiplier
    assign diff_cmd = $signed({1'b0, r_cmd}) - $signed({1'b0, r_thrust});
    always_comb begin
        case (i_cw.src)
            SRC_ERR:  opnd = {{9{r_err[31]}}, r_err};
            SRC_SUM:  opnd = {r_error_sum[39], r_error_sum};
            SRC_DOP:  opnd = {{8{r_dop[32]}}, r_dop};
            SRC_DIFF: opnd = {{9{diff_cmd[31]}}, diff_cmd};
            default:  opnd = '0;
        endcase
        case (i_cw.gsel)
            GAIN_KP:    gain_sel = r_kp;
            GAIN_KI:    gain_sel = r_ki;
            GAIN_KD:    gain_sel = r_kd;
            default:    gain_sel = {7'd0, r_alpha};
        endcase
    end
    assign opnd_abs = opnd[40] ? (~opnd + 41'd1) : opnd;

    // shared 32x24 multiplier, low then high slice of the magnitude
    assign mul_a = (i_cw.op == UOP_MHI) ? {24'd0, r_mag[39:32]} : r_mag[31:0];
    assign mul_p = {24'd0, mul_a} * {32'd0, r_gain};

    // rounded quotient with sign and saturation
    assign rq = r_acc[63:16];
    always_comb begin
        if (!r_neg) begin
            term_sat = (rq > 48'h0000_7FFF_FFFF) ? S32_TOP : rq[31:0];
        end else begin
            term_sat = (rq > 48'h0000_8000_0000) ? S32_BOT : (~rq[31:0] + 32'd1);
        end
    end
    assign delta = r_neg ? (~rq[31:0] + 32'd1) : rq[31:0];
    assign thrust_sum = {1'b0, r_thrust} + delta;

    // thrust command clamp
    assign cmd_raw = {{2{r_pt[31]}}, r_pt} + {{2{r_it[31]}}, r_it} + {{2{r_dt[31]}}, r_dt};
    always_comb begin
        if (cmd_raw[33]) begin
            cmd_clamp = '0;
        end else if (cmd_raw > $signed({3'b000, r_tlim})) begin
            cmd_clamp = r_tlim;
        end else begin
            cmd_clamp = cmd_raw[30:0];
        end
    end

    assign res_load = (i_cw.op == UOP_OUT) && !i_out_busy;
    assign o_res_load = res_load;
    assign o_alpha_one = (r_alpha == ONE_Q16);

    // configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
            r_ilim <= '0;
            r_tlim <= '0;
            r_alpha <= ONE_Q16;
            r_dmeas <= 1'b0;
            r_error_sum <= '0;
            r_last_error <= '0;
            r_last_meas <= '0;
            r_thrust <= '0;
            r_tick <= '0;
            r_ticked <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TARGET: begin
                        r_target <= i_cfg_data[31:0];
                        if (!r_ticked) begin
                            r_last_error <= i_cfg_data[31:0];
                        end
                    end
                    CFG_KP:    r_kp <= i_cfg_data[23:0];
                    CFG_KI:    r_ki <= i_cfg_data[23:0];
                    CFG_KD:    r_kd <= i_cfg_data[23:0];
                    CFG_ILIM:  r_ilim <= i_cfg_data[38:0];
                    CFG_TLIM:  r_tlim <= i_cfg_data[30:0];
                    CFG_ALPHA: r_alpha <= (i_cfg_data[16:0] > ONE_Q16) ? ONE_Q16
                                                                       : i_cfg_data[16:0];
                    CFG_DMEAS: r_dmeas <= i_cfg_data[0];
                    default:   r_dmeas <= r_dmeas;
                endcase
            end
            if (i_cw.op == UOP_INTEG) begin
                r_error_sum <= sum_clamp;
            end
            if (i_cw.op == UOP_LAG) begin
                r_thrust <= thrust_sum[30:0];
            end
            if (i_cw.op == UOP_INSTANT) begin
                r_thrust <= r_cmd;
            end
            if (res_load) begin
                r_last_error <= r_err;
                r_last_meas <= r_meas;
                r_tick <= r_tick + 32'd1;
                r_ticked <= 1'b1;
            end
        end
    end

    // working registers, one operation per step
    always_ff @(posedge i_clk) begin
        if (i_cw.src != SRC_NONE) begin
            r_neg <= opnd[40];
            r_mag <= opnd_abs[39:0];
            r_gain <= gain_sel;
        end
        case (i_cw.op)
            UOP_ACCEPT: r_meas <= i_measured_altitude;
            UOP_ERR:    r_err <= err_sat;
            UOP_INTEG:  r_dop <= dop_new;
            UOP_MLO:    r_prod <= mul_p;
            UOP_MHI: begin
                r_acc <= {8'd0, r_prod} + 64'h8000;
                r_prod <= mul_p;
            end
            UOP_ACC:    r_acc <= r_acc + {r_prod[31:0], 32'd0};
            UOP_WB: begin
                case (i_cw.dst)
                    DST_P:   r_pt <= term_sat;
                    DST_I:   r_it <= term_sat;
                    DST_D:   r_dt <= term_sat;
                    default: r_pt <= r_pt;
                endcase
            end
            UOP_CMD:    r_cmd <= cmd_clamp;
            default:    r_cmd <= r_cmd;
        endcase
    end

    assign o_result.sample_index = r_tick;
    assign o_result.control_error = r_err;
    assign o_result.prop_term = r_pt;
    assign o_result.integ_term = r_it;
    assign o_result.deriv_term = r_dt;
    assign o_result.applied_thrust = r_thrust;

endmodule

[src/pid_thrust_controller.sv]
// PID thrust controller: one altitude sample in, one control result out.
// Input word: i_measured_altitude, accepted when i_in_valid is high and
// o_in_stall is low. Result word: sample index, error, P/I/D terms and
// applied thrust, taken when o_out_valid is high and i_out_stall is low.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index;
// write only while no sample is in flight.
// The control program drives one shared 32x24 multiplier through four
// two-slice products in turn, or three when lag_alpha is one (the lag
// multiply is skipped). A new sample is taken only once the previous
// result has been loaded into the output register.
// The result sits in an output register; a stalled receiver holds it, and the
// block keeps computing the next sample, waiting only at its final step until
// the register frees.
// Reset clears the configuration and controller state to defaults; the
// sequencer returns to its idle step, ready to take a sample.
// Depends on ptc_pkg, ptc_sequencer and ptc_datapath.
module pid_thrust_controller
    import ptc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [31:0]    i_measured_altitude,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [31:0]           o_sample_index,
    output logic signed [31:0]    o_control_error,
    output logic signed [31:0]    o_prop_term,
    output logic signed [31:0]    o_integ_term,
    output logic signed [31:0]    o_deriv_term,
    output logic [30:0]           o_applied_thrust
);

    t_ucode      cw;
    t_seq_status status;
    t_result     result;
    t_result     r_out;
    logic        r_out_valid;
    logic        res_load;
    logic        alpha_one;
    logic        out_busy;

    assign out_busy = r_out_valid && i_out_stall;
    assign status.in_valid = i_in_valid;
    assign status.out_busy = out_busy;
    assign status.alpha_one = alpha_one;

    ptc_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cw     (cw)
    );

    ptc_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_measured_altitude (i_measured_altitude),
        .i_cw                (cw),
        .i_out_busy          (out_busy),
        .o_alpha_one         (alpha_one),
        .o_res_load          (res_load),
        .o_result            (result)
    );

    // take a sample only at the idle step
    assign o_in_stall = (cw.op != UOP_ACCEPT);

    // output register: load a result, drop the word once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample_index = r_out.sample_index;
    assign o_control_error = r_out.control_error;
    assign o_prop_term = r_out.prop_term;
    assign o_integ_term = r_out.integ_term;
    assign o_deriv_term = r_out.deriv_term;
    assign o_applied_thrust = r_out.applied_thrust;

`ifndef SYNTHESIS
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> !out_busy)
        else $error("result loaded while output word still stalled");

    // an accepted sample moves the sequencer off the idle step
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer stayed idle after taking a sample");

    // a loaded result is visible in the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> o_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

[tb/pid_thrust_controller_tb.sv]
// Self-checking testbench for pid_thrust_controller: a queue-fed driver, a stalling receiver
// and a bit-exact fixed-point predictor of the error, P/I/D terms and lagged thrust.
// Depends on ptc_pkg for the register indexes and the result layout.
module pid_thrust_controller_tb;
    import ptc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint S32_TOP = 64'sd2147483647;
    localparam longint S32_BOT = -64'sd2147483648;
    localparam int RANDOM_SAMPLES = 1730;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic signed [31:0]    i_measured_altitude = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [31:0]           o_sample_index;
    logic signed [31:0]    o_control_error;
    logic signed [31:0]    o_prop_term;
    logic signed [31:0]    o_integ_term;
    logic signed [31:0]    o_deriv_term;
    logic [30:0]           o_applied_thrust;

    pid_thrust_controller u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_measured_altitude(i_measured_altitude),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_sample_index     (o_sample_index),
        .o_control_error    (o_control_error),
        .o_prop_term        (o_prop_term),
        .o_integ_term       (o_integ_term),
        .o_deriv_term       (o_deriv_term),
        .o_applied_thrust   (o_applied_thrust)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // controller settings as the predictor sees them
    longint          ctl_target = 0;
    longint unsigned ctl_kp = 0;
    longint unsigned ctl_ki = 0;
    longint unsigned ctl_kd = 0;
    longint          ctl_ilim = 0;
    longint          ctl_tlim = 0;
    longint unsigned ctl_alpha = 65536;
    bit              ctl_dmeas = 1'b0;

    // loop state of the predicted controller
    longint      sum_err = 0;
    longint      prev_err = 0;
    longint      prev_meas = 0;
    longint      thrust_now = 0;
    logic [31:0] tick_no = '0;
    bit          has_ticked = 1'b0;

    logic signed [31:0] altitude_queue[$];
    t_result            due_results[$];

    int  send_gap_max = 0;
    int  recv_gap_max = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  hold_off = 1'b0;
    int  samples_taken = 0;
    int  results_checked = 0;
    int  mismatches = 0;
    int  setups = 0;

    function automatic longint sat_s32(input longint v);
        if (v > S32_TOP) return S32_TOP;
        if (v < S32_BOT) return S32_BOT;
        return v;
    endfunction

    // gain * a / 2^16, rounded to nearest with ties away from zero
    function automatic longint scale_q16(input longint a, input longint unsigned g);
        bit              neg;
        longint unsigned mag;
        longint unsigned r;
        neg = a < 0;
        mag = neg ? -a : a;
        r = (mag * g + 64'd32768) >> 16;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // advance the predicted controller by one tick and return its result word
    function automatic t_result compute_control(input logic signed [31:0] meas);
        longint  m, err, acc, dop, pt, it, dt, cmd;
        t_result r;
        m = longint'(meas);
        err = sat_s32(ctl_target - m);
        acc = sum_err + err;
        if (acc > ctl_ilim) acc = ctl_ilim;
        if (acc < -ctl_ilim) acc = -ctl_ilim;
        sum_err = acc;
        dop = ctl_dmeas ? prev_meas - m : err - prev_err;
        pt = sat_s32(scale_q16(err, ctl_kp));
        it = sat_s32(scale_q16(sum_err, ctl_ki));
        dt = sat_s32(scale_q16(dop, ctl_kd));
        cmd = pt + it + dt;
        if (cmd < 0) cmd = 0;
        if (cmd > ctl_tlim) cmd = ctl_tlim;
        thrust_now = thrust_now + scale_q16(cmd - thrust_now, ctl_alpha);
        r.sample_index = tick_no;
        r.control_error = err[31:0];
        r.prop_term = pt[31:0];
        r.integ_term = it[31:0];
        r.deriv_term = dt[31:0];
        r.applied_thrust = thrust_now[30:0];
        prev_err = err;
        prev_meas = m;
        tick_no = tick_no + 32'd1;
        has_ticked = 1'b1;
        return r;
    endfunction

    function automatic int draw_wait(input int max_wait);
        return $urandom_range(0, max_wait);
    endfunction

    // raise the write enable for one register; the caller drops it with cfg_done
    task automatic cfg_write(input t_cfg_idx idx, input logic [38:0] val);
        logic signed [31:0] tgt;
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TARGET: begin
                tgt = val[31:0];
                ctl_target = longint'(tgt);
                if (!has_ticked) prev_err = ctl_target;
            end
            CFG_KP:    ctl_kp = 64'(val[23:0]);
            CFG_KI:    ctl_ki = 64'(val[23:0]);
            CFG_KD:    ctl_kd = 64'(val[23:0]);
            CFG_ILIM:  ctl_ilim = 64'(val[38:0]);
            CFG_TLIM:  ctl_tlim = 64'(val[30:0]);
            CFG_ALPHA: begin
                ctl_alpha = 64'(val[16:0]);
                if (ctl_alpha > 65536) ctl_alpha = 65536;
            end
            CFG_DMEAS: ctl_dmeas = val[0];
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        setups++;
    endtask

    // hold until every queued word is accepted and every result is back
    task automatic drain();
        while (altitude_queue.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
    endtask

    // on a coin flip, set random bits above the register width, which the block must drop
    function automatic logic [38:0] with_junk(input logic [38:0] v, input int w);
        logic [63:0] junk;
        junk = {$urandom, $urandom} << w;
        if ($urandom_range(0, 1) != 0) v = v | junk[38:0];
        return v;
    endfunction

    function automatic logic [38:0] pick_field(input int w, input logic [38:0] typical);
        logic [63:0] mask;
        logic [63:0] bits;
        mask = (64'd1 << w) - 64'd1;
        bits = {$urandom, $urandom} & mask;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return mask[38:0];
            2: return bits[38:0];
            default: return typical;
        endcase
    endfunction

    task automatic random_setup();
        logic [38:0] v;
        case ($urandom_range(0, 5))
            0: v = 39'h0_7FFF_FFFF;
            1: v = 39'h0_8000_0000;
            2: v = 39'($urandom);
            default: v = 39'($urandom_range(0, 32'h00C8_0000) - 32'h0064_0000);
        endcase
        cfg_write(CFG_TARGET, with_junk({7'd0, v[31:0]}, 32));
        cfg_write(CFG_KP, with_junk(pick_field(24, 39'($urandom_range(0, 32'h0004_0000))), 24));
        cfg_write(CFG_KI, with_junk(pick_field(24, 39'($urandom_range(0, 32'h0001_0000))), 24));
        cfg_write(CFG_KD, with_junk(pick_field(24, 39'($urandom_range(0, 32'h0002_0000))), 24));
        cfg_write(CFG_ILIM, pick_field(39, 39'($urandom_range(0, 32'h03E8_0000))));
        cfg_write(CFG_TLIM, with_junk(pick_field(31, 39'($urandom_range(32'h0001_0000,
                                                                        32'h0064_0000))), 31));
        case ($urandom_range(0, 4))
            0: v = 39'd65536;
            1: v = '0;
            2: v = 39'($urandom_range(65537, 131071));
            default: v = 39'($urandom_range(0, 65536));
        endcase
        cfg_write(CFG_ALPHA, with_junk(v, 17));
        cfg_write(CFG_DMEAS, with_junk(39'($urandom_range(0, 1)), 1));
        cfg_done();
    endtask

    // sender: present a word, hold it while stalled, then wait a drawn gap
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            due_results.push_back(compute_control(i_measured_altitude));
            samples_taken++;
            send_wait = draw_wait(send_gap_max);
            if (send_wait == 0 && altitude_queue.size() != 0) begin
                i_measured_altitude <= altitude_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (send_wait != 0) begin
                send_wait--;
            end else if (altitude_queue.size() != 0) begin
                i_in_valid <= 1'b1;
                i_measured_altitude <= altitude_queue.pop_front();
            end
        end
    end

    // receiver: compare each taken word with the oldest prediction, then stall a while
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (o_out_valid && !i_out_stall) begin
            results_checked++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d thrust %h",
                             o_sample_index, o_applied_thrust);
            end else begin
                want = due_results.pop_front();
                if (o_sample_index !== want.sample_index
                    || o_control_error !== want.control_error
                    || o_prop_term !== want.prop_term
                    || o_integ_term !== want.integ_term
                    || o_deriv_term !== want.deriv_term
                    || o_applied_thrust !== want.applied_thrust) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: idx %h err %h p %h i %h d %h thr %h",
                                 want.sample_index, want.control_error, want.prop_term,
                                 want.integ_term, want.deriv_term, want.applied_thrust);
                        $display("         got: idx %h err %h p %h i %h d %h thr %h",
                                 o_sample_index, o_control_error, o_prop_term,
                                 o_integ_term, o_deriv_term, o_applied_thrust);
                    end
                end
            end
            recv_wait = draw_wait(recv_gap_max);
        end else if (recv_wait != 0) begin
            recv_wait--;
        end
        i_out_stall <= hold_off || (recv_wait != 0);
    end

    // long receiver hold-off mid-run so the block backs up into its input
    initial begin
        wait (samples_taken >= 700);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic signed [31:0] alt;
        logic signed [31:0] tgt;
        int                 random_total;
        int                 n;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // moderate gains; setpoint written before the first tick seeds the old error
        cfg_write(CFG_TARGET, 39'h0_0010_0000);
        cfg_write(CFG_KP, 39'h1_0000);
        cfg_write(CFG_KI, 39'h4000);
        cfg_write(CFG_KD, 39'h8000);
        cfg_write(CFG_ILIM, 39'h4_0000);
        cfg_write(CFG_TLIM, 39'h0100_0000);
        cfg_write(CFG_ALPHA, 39'h8000);
        cfg_write(CFG_DMEAS, 39'd0);
        cfg_done();
        altitude_queue.push_back(32'sh0000_0000);
        altitude_queue.push_back(32'sh7FFF_FFFF);
        altitude_queue.push_back(32'sh8000_0000);
        altitude_queue.push_back(32'sh0010_0000);
        altitude_queue.push_back(32'shFFFF_FFFF);
        altitude_queue.push_back(32'sh0008_0000);
        altitude_queue.push_back(32'sh0020_0000);
        drain();

        // full-scale gains and limits, instant lag, derivative on measurement
        cfg_write(CFG_TARGET, 39'h0_7FFF_FFFF);
        cfg_write(CFG_KP, 39'hFF_FFFF);
        cfg_write(CFG_KI, 39'hFF_FFFF);
        cfg_write(CFG_KD, 39'hFF_FFFF);
        cfg_write(CFG_ILIM, 39'h7F_FFFF_FFFF);
        cfg_write(CFG_TLIM, 39'h7FFF_FFFF);
        cfg_write(CFG_ALPHA, 39'h1_0000);
        cfg_write(CFG_DMEAS, 39'd1);
        cfg_done();
        altitude_queue.push_back(32'sh8000_0000);
        altitude_queue.push_back(32'sh7FFF_FFFF);
        altitude_queue.push_back(32'sh8000_0000);
        altitude_queue.push_back(32'sh0000_0000);
        altitude_queue.push_back(32'sh8000_0000);
        altitude_queue.push_back(32'sh8000_0000);
        drain();

        // zero limits, alpha above one, derivative back on error
        cfg_write(CFG_TARGET, 39'h0_8000_0000);
        cfg_write(CFG_KP, 39'd0);
        cfg_write(CFG_ILIM, 39'd0);
        cfg_write(CFG_TLIM, 39'd0);
        cfg_write(CFG_ALPHA, 39'h1_FFFF);
        cfg_write(CFG_DMEAS, 39'd0);
        cfg_done();
        altitude_queue.push_back(32'sh7FFF_FFFF);
        altitude_queue.push_back(32'sh0000_0000);
        altitude_queue.push_back(32'sh8000_0000);
        altitude_queue.push_back(32'sh1234_5678);
        drain();

        // frozen lag: thrust must not move from its last value
        cfg_write(CFG_TARGET, 39'h0_0050_0000);
        cfg_write(CFG_KP, 39'h2_0000);
        cfg_write(CFG_TLIM, 39'h7FFF_FFFF);
        cfg_write(CFG_ALPHA, 39'd0);
        cfg_done();
        altitude_queue.push_back(32'sh0000_0000);
        altitude_queue.push_back(32'shFFB0_0000);
        altitude_queue.push_back(32'sh0050_0000);
        drain();

        // random phases: fresh settings, drifting altitude with bursts of noise
        random_total = 0;
        while (random_total < RANDOM_SAMPLES) begin
            random_setup();
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            n = $urandom_range(100, 190);
            tgt = ctl_target[31:0];
            alt = tgt + $urandom_range(0, 32'h0014_0000) - 32'h000A_0000;
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: alt = alt + $urandom_range(0, 131072) - 65536;
                    5, 6: alt = $urandom;
                    7: begin
                        case ($urandom_range(0, 3))
                            0: alt = 32'sh7FFF_FFFF;
                            1: alt = 32'sh8000_0000;
                            2: alt = '0;
                            default: alt = tgt;
                        endcase
                    end
                    default: alt = tgt + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                endcase
                altitude_queue.push_back(alt);
            end
            random_total += n;
            drain();
        end

        // let any stray result show up before the verdict
        repeat (40) @(posedge i_clk);
        $display("Summary: %0d altitude samples over %0d register setups, %0d results checked",
                 samples_taken, setups, results_checked);
        $display("Summary: %0d mismatching or unexpected results", mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
